// File: src/assert_macros.svh
// Concurrent assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, disabled while in reset.
`define AST_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, sampled on clk_i, disabled while in reset.
`define AST_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

// File: src/i2c_tsr_pkg.sv
// Types, constants and reset values of the temperature sensor register slave.
package i2c_tsr_pkg;

  localparam int unsigned NumRegs   = 16;
  localparam int unsigned RegAddrW  = $clog2(NumRegs);
  localparam int unsigned RegW      = 16;
  localparam int unsigned BytePosW  = 6;
  localparam int unsigned TempW     = 12;
  localparam int unsigned FuncW     = 2;

  localparam logic [BytePosW-1:0] BytePosMax = '1;
  localparam logic [7:0]          FillByte   = 8'hFF;

  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_TEMP  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef logic [RegW-1:0] reg_word_t;

  function automatic reg_word_t reg_reset_value(input logic [RegAddrW-1:0] idx);
    reg_word_t val;
    val = '0;
    unique case (idx)
      4'd1:    val = 16'h00FF;
      4'd2:    val = 16'h4B00;
      4'd3:    val = 16'h5000;
      4'd15:   val = 16'h7500;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: src/i2c_temp_sensor_register_slave.sv
// Byte-level I2C register slave of a temperature sensor, with result register.
//
// Input channel s_axis_*: one transaction per bus byte or temperature update.
//   tuser carries the function code and the first-byte flag, tdata the
//   written byte and the signed temperature in sixteenths of a degree.
// Output channel m_axis_*: one transaction per input transaction, in order.
//   tuser carries the ACK bit, tdata the byte returned on a bus read.
// The result is registered and appears in the cycle after its input transaction is taken.
// Throughput: one transaction per cycle while the receiver does not stall. The
//   pointer, byte position, abort flag and register file are updated in the
//   same cycle the input is taken, so the next item sees them without a
//   bubble; each result passes through the single result register.
// Reset clears the pointer, byte position and abort flag and loads the
//   register file with its power-on values; no result is pending after reset.
// When the receiver stalls, the result register holds its transaction and
//   s_axis_tready drops until it is taken; a result taken in the same cycle
//   frees the register for the next input.
`include "assert_macros.svh"

module i2c_temp_sensor_register_slave
  import i2c_tsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] wr_byte, [19:8] temperature, [23:20] zero
  input  logic [2:0]  s_axis_tuser,  // [1:0] func, [2] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] rd_byte
  output logic        m_axis_tuser   // [0] ack
);

  reg_word_t             reg_file_q [NumRegs];
  logic [RegAddrW-1:0]   pointer_q, pointer_d;
  logic [BytePosW-1:0]   byte_pos_q, byte_pos_d;
  logic                  aborted_q, aborted_d;
  logic                  out_valid_q;
  logic                  ack_q, ack_d;
  logic [7:0]            rd_byte_q, rd_byte_d;

  logic                  in_fire;
  func_e                 func;
  logic                  first;
  logic [7:0]            wr_byte;
  logic [TempW-1:0]      temperature;
  logic [BytePosW-1:0]   pos;
  logic                  abort_in;
  logic [BytePosW-2:0]   offs;
  logic [BytePosW-1:0]   rd_addr;
  reg_word_t             cur_word;
  logic                  wr_hi, wr_lo, wr_temp;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign func        = func_e'(s_axis_tuser[1:0]);
  assign first       = s_axis_tuser[2];
  assign wr_byte     = s_axis_tdata[7:0];
  assign temperature = s_axis_tdata[19:8];

  // A first byte restarts the transaction position and clears any abort.
  assign pos      = first ? '0 : byte_pos_q;
  assign abort_in = first ? 1'b0 : aborted_q;
  assign offs     = pos[BytePosW-1:1];
  assign rd_addr  = BytePosW'(pointer_q) + BytePosW'(offs);
  assign cur_word = reg_file_q[pointer_q];

  always_comb begin
    pointer_d  = pointer_q;
    byte_pos_d = byte_pos_q;
    aborted_d  = aborted_q;
    ack_d      = 1'b0;
    rd_byte_d  = '0;
    wr_hi      = 1'b0;
    wr_lo      = 1'b0;
    wr_temp    = 1'b0;
    unique case (func)
      FUNC_TEMP: begin
        wr_temp = 1'b1;
        ack_d   = 1'b1;
      end
      FUNC_NONE: begin
        ack_d = 1'b0;
      end
      FUNC_WRITE: begin
        byte_pos_d = pos;
        aborted_d  = abort_in;
        if (!abort_in) begin
          if (pos == '0) begin
            if (wr_byte[7:4] != 4'h0) begin
              aborted_d = 1'b1;
            end else begin
              pointer_d  = wr_byte[RegAddrW-1:0];
              byte_pos_d = BytePosW'(1);
              ack_d      = 1'b1;
            end
          end else if (pos > BytePosW'(2) || pointer_q < RegAddrW'(1)
                       || pointer_q > RegAddrW'(3)) begin
            // Read-only register or third data byte: refuse.
            aborted_d = 1'b1;
          end else begin
            wr_hi      = (pos == BytePosW'(1));
            wr_lo      = (pos == BytePosW'(2));
            byte_pos_d = pos + BytePosW'(1);
            ack_d      = 1'b1;
          end
        end
      end
      FUNC_READ: begin
        byte_pos_d = pos;
        aborted_d  = abort_in;
        if (!abort_in) begin
          if (rd_addr > BytePosW'(NumRegs - 1)) begin
            aborted_d = 1'b1;
          end else begin
            if (offs != '0) begin
              rd_byte_d = FillByte;
            end else if (pos == '0) begin
              rd_byte_d = cur_word[15:8];
            end else begin
              rd_byte_d = cur_word[7:0];
            end
            ack_d = 1'b1;
            if (pos != BytePosMax) begin
              byte_pos_d = pos + BytePosW'(1);
            end
          end
        end
      end
      default: ack_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pointer_q   <= '0;
      byte_pos_q  <= '0;
      aborted_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumRegs; i++) begin
        reg_file_q[i] <= reg_reset_value(RegAddrW'(i));
      end
    end else begin
      if (in_fire) begin
        pointer_q   <= pointer_d;
        byte_pos_q  <= byte_pos_d;
        aborted_q   <= aborted_d;
        out_valid_q <= 1'b1;
        if (wr_temp) begin
          reg_file_q[0] <= {temperature, 4'h0};
        end
        if (wr_hi) begin
          reg_file_q[pointer_q][15:8] <= wr_byte;
        end
        if (wr_lo) begin
          reg_file_q[pointer_q][7:0] <= wr_byte;
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ack_q     <= ack_d;
      rd_byte_q <= rd_byte_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rd_byte_q;
  assign m_axis_tuser  = ack_q;

  // A NAK never carries read data.
  `AST_IMPLY(a_nak_no_data, out_valid_q && !ack_q, rd_byte_q == 8'h00)
  // A temperature update lands in register zero on the next cycle.
  `AST_NEXT(a_temp_load, in_fire && func == FUNC_TEMP,
            reg_file_q[0] == {$past(temperature), 4'h0})
  // Register fifteen is read-only.
  `AST_NEXT(a_ro_reg, 1'b1, $stable(reg_file_q[NumRegs-1]))
  // Pointer and byte position move only on an accepted transaction.
  `AST_NEXT(a_state_hold, !in_fire, $stable(pointer_q) && $stable(byte_pos_q))

endmodule
